// ===== sv/prt_pkg.sv =====
package prt_pkg;

	localparam int FLOWS     = 16;
	localparam int FLOW_BITS = $clog2(FLOWS);
	localparam int WIN_BITS  = 5;
	localparam int WINDOW    = 1 << WIN_BITS;
	localparam int SEQ_BITS  = 16;
	localparam int LEN_BITS  = 8;
	localparam int PARK_BITS = 13;
	localparam int REL_BITS  = WIN_BITS + 1;
	localparam int CNT_BITS  = 32;
	localparam int QDEPTH    = 2;
	localparam int QPTR_BITS = $clog2(QDEPTH);
	localparam int QCNT_BITS = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		ST_IN_ORDER = 2'd0,
		ST_PARKED   = 2'd1,
		ST_STALE    = 2'd2,
		ST_BEYOND   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DRAIN,
		BK_DONE
	} back_state_t;

	typedef struct packed {
		logic [3:0]  flow;
		logic [15:0] packet_seq;
		logic [7:0]  flit_length;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [5:0]  released;
		logic [12:0] flow_parked_flits;
		logic [31:0] flow_received;
		logic [31:0] flow_out_of_order;
		logic [15:0] next_expected;
	} out_item_t;

	typedef struct packed {
		logic                 valid;
		logic [FLOW_BITS-1:0] flow;
		logic [SEQ_BITS-1:0]  seq;
		logic [LEN_BITS-1:0]  len;
	} work_t;

	typedef struct packed {
		logic      push;
		out_item_t result;
	} result_push_t;

	function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
		sat_inc = (v == {CNT_BITS{1'b1}}) ? v : v + CNT_BITS'(1);
	endfunction

endpackage

// ===== sv/prt_front.sv =====
module prt_front
	import prt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t item,
	input  logic     take,
	output work_t    work
);

	in_item_t               buf_q [QDEPTH];
	logic [QPTR_BITS-1:0]   wr_q;
	logic [QPTR_BITS-1:0]   rd_q;
	logic [QCNT_BITS-1:0]   cnt_q;
	logic                   wr_en;
	logic                   rd_en;
	in_item_t               head;

	assign full  = (cnt_q == QCNT_BITS'(QDEPTH));
	assign wr_en = push && !full;
	assign rd_en = take && (cnt_q != '0);
	assign head  = buf_q[rd_q];

	// Decode the head transaction: flow folded onto the flow table, fields trimmed.
	always_comb begin
		work.valid = (cnt_q != '0);
		work.flow  = head.flow[FLOW_BITS-1:0];
		work.seq   = head.packet_seq[SEQ_BITS-1:0];
		work.len   = head.flit_length[LEN_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= (wr_q == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_q + QPTR_BITS'(1);
			end
			if (rd_en) begin
				rd_q <= (rd_q == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_q + QPTR_BITS'(1);
			end
			cnt_q <= cnt_q + QCNT_BITS'(wr_en) - QCNT_BITS'(rd_en);
		end
	end

endmodule

// ===== sv/prt_back.sv =====
module prt_back
	import prt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  work_t        work,
	output logic         take,
	input  logic         out_full,
	output result_push_t res
);

	back_state_t          state_q;
	back_state_t          state_nxt;

	logic [SEQ_BITS-1:0]  exp_q    [FLOWS];
	logic [WINDOW-1:0]    valid_q  [FLOWS];
	logic [PARK_BITS-1:0] parked_q [FLOWS];
	logic [CNT_BITS-1:0]  rcv_q    [FLOWS];
	logic [CNT_BITS-1:0]  ooo_q    [FLOWS];

	// Slot lengths, one ring of WINDOW entries per flow, addressed by the low sequence bits.
	logic [LEN_BITS-1:0]  len_mem  [FLOWS * WINDOW];
	logic [LEN_BITS-1:0]  rdata_s1;
	logic                 rd_pend_s1;

	logic [FLOW_BITS-1:0] f_q;
	logic [REL_BITS-1:0]  rel_q;
	logic [WIN_BITS-1:0]  idx_q;

	logic [FLOW_BITS-1:0] cur_f;
	logic [SEQ_BITS-1:0]  cur_exp;
	logic [SEQ_BITS-1:0]  seq_diff;
	logic [WIN_BITS-1:0]  slot_idx;
	logic                 in_win;
	logic                 slot_busy;
	logic                 go;
	logic                 park;
	logic                 cont;

	assign cur_f     = (state_q == BK_IDLE) ? work.flow : f_q;
	assign cur_exp   = exp_q[cur_f];
	assign seq_diff  = work.seq - cur_exp;
	assign slot_idx  = work.seq[WIN_BITS-1:0];
	assign in_win    = (seq_diff < SEQ_BITS'(WINDOW));
	assign slot_busy = valid_q[cur_f][slot_idx];
	assign go        = (state_q == BK_IDLE) && work.valid && !out_full;
	assign park      = go && (seq_diff != '0) && in_win && !slot_busy;
	assign cont      = (rel_q < REL_BITS'(WINDOW)) && valid_q[f_q][idx_q];

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (go && (seq_diff == '0)) begin
					state_nxt = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				if (!cont) begin
					state_nxt = BK_DONE;
				end
			end
			BK_DONE: begin
				state_nxt = BK_IDLE;
			end
			default: begin
				state_nxt = BK_IDLE;
			end
		endcase
	end

	always_comb begin
		take                         = go;
		res.push                     = 1'b0;
		res.result.status            = ST_IN_ORDER;
		res.result.released          = '0;
		res.result.flow_parked_flits = parked_q[cur_f];
		res.result.flow_received     = rcv_q[cur_f];
		res.result.flow_out_of_order = ooo_q[cur_f];
		res.result.next_expected     = cur_exp;
		unique case (state_q)
			BK_IDLE: begin
				res.push = go && (seq_diff != '0);
				priority if (in_win) begin
					res.result.status = slot_busy ? ST_STALE : ST_PARKED;
				end else if (seq_diff[SEQ_BITS-1]) begin
					res.result.status = ST_STALE;
				end else begin
					res.result.status = ST_BEYOND;
				end
				if (park) begin
					res.result.flow_parked_flits = parked_q[cur_f] + PARK_BITS'(work.len);
				end
			end
			BK_DONE: begin
				res.push                 = 1'b1;
				res.result.released      = 6'(rel_q);
				res.result.next_expected = cur_exp + SEQ_BITS'(rel_q);
			end
			BK_DRAIN: begin
				res.push = 1'b0;
			end
			default: begin
				res.push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (park) begin
			len_mem[{work.flow, slot_idx}] <= work.len;
		end
		rdata_s1 <= len_mem[{f_q, idx_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			rd_pend_s1 <= 1'b0;
			f_q        <= '0;
			rel_q      <= '0;
			idx_q      <= '0;
			for (int i = 0; i < FLOWS; i++) begin
				exp_q[i]    <= '0;
				valid_q[i]  <= '0;
				parked_q[i] <= '0;
				rcv_q[i]    <= '0;
				ooo_q[i]    <= '0;
			end
		end else begin
			state_q    <= state_nxt;
			rd_pend_s1 <= (state_q == BK_DRAIN) && cont;
			if (go) begin
				f_q <= work.flow;
				if (seq_diff == '0) begin
					rcv_q[cur_f] <= sat_inc(rcv_q[cur_f]);
					rel_q        <= REL_BITS'(1);
					idx_q        <= cur_exp[WIN_BITS-1:0] + WIN_BITS'(1);
				end
			end
			if (park) begin
				valid_q[cur_f][slot_idx] <= 1'b1;
				parked_q[cur_f]          <= parked_q[cur_f] + PARK_BITS'(work.len);
			end
			if ((state_q == BK_DRAIN) && cont) begin
				valid_q[f_q][idx_q] <= 1'b0;
				rcv_q[f_q]          <= sat_inc(rcv_q[f_q]);
				ooo_q[f_q]          <= sat_inc(ooo_q[f_q]);
				rel_q               <= rel_q + REL_BITS'(1);
				idx_q               <= idx_q + WIN_BITS'(1);
			end
			if (rd_pend_s1) begin
				parked_q[f_q] <= parked_q[f_q] - PARK_BITS'(rdata_s1);
			end
			if (state_q == BK_DONE) begin
				exp_q[f_q] <= exp_q[f_q] + SEQ_BITS'(rel_q);
			end
		end
	end

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_DONE |=> state_q == BK_IDLE)
		else $error("drain did not return to idle after its result");

	a_no_pending_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_DONE |-> !rd_pend_s1)
		else $error("length subtraction still pending when the result is formed");

	a_rel_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != BK_IDLE |-> (rel_q != '0) && (rel_q <= REL_BITS'(WINDOW)))
		else $error("release count out of range");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res.push |-> !out_full)
		else $error("result pushed into a full queue");

	a_no_park_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> !park)
		else $error("parking collided with a drain subtraction");

endmodule

// ===== sv/prt_out.sv =====
module prt_out
	import prt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  result_push_t res,
	output logic         out_full,
	output logic         empty,
	input  logic         pop,
	output out_item_t    result
);

	out_item_t            buf_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_q;
	logic [QPTR_BITS-1:0] rd_q;
	logic [QCNT_BITS-1:0] cnt_q;
	logic                 wr_en;
	logic                 rd_en;

	assign out_full = (cnt_q == QCNT_BITS'(QDEPTH));
	assign empty    = (cnt_q == '0);
	assign wr_en    = res.push && !out_full;
	assign rd_en    = pop && !empty;
	assign result   = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_q[wr_q] <= res.result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= (wr_q == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_q + QPTR_BITS'(1);
			end
			if (rd_en) begin
				rd_q <= (rd_q == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_q + QPTR_BITS'(1);
			end
			cnt_q <= cnt_q + QCNT_BITS'(wr_en) - QCNT_BITS'(rd_en);
		end
	end

endmodule

// ===== sv/packet_reorder_tracker.sv =====
// Per-flow packet reorder tracker.
// Arriving packet heads (flow, sequence number, length in flits) are pushed as
// transactions on the input queue interface: a transaction is taken when push is
// high and full is low. Every head yields exactly one result transaction on the
// output queue interface: the oldest result sits on result while empty is low and
// is taken when pop is high and empty is low.
// A two-entry input queue decouples the sender from the execution engine, and a
// two-entry result queue decouples the engine from the receiver, so a stalled
// receiver only halts intake once both queues have filled.
// A head that is parked, dropped as stale or duplicate, or found beyond the window
// is handled in the idle state, which pushes its result into the result queue in
// the cycle the head is taken. An in-order head moves the engine from idle into
// the drain state, which releases one parked successor per cycle and reads its
// slot length from the length memory, and then into the done state, which pushes
// its result; the engine takes no new head until it is back in idle. Parked or
// dropped heads pass at one head per cycle while the result queue has room.
// Reset clears both queues, sets every flow to expect sequence number zero,
// empties every parking window and zeroes the parked-flit and delivery totals.
module packet_reorder_tracker
	import prt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	// Head transaction decoded by the front end and its acknowledge from the engine.
	work_t        work;
	logic         take;

	// Result push from the engine into the output queue, with back-pressure.
	result_push_t res;
	logic         out_full;

	prt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.take   (take),
		.work   (work)
	);

	// The engine holds all per-flow state: expected numbers, window valid bits,
	// parked-flit totals and the saturating delivery counters.
	prt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.work     (work),
		.take     (take),
		.out_full (out_full),
		.res      (res)
	);

	prt_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.out_full (out_full),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

// ===== sim/prt_result_checker.sv =====
module prt_result_checker
	import prt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  in_item_t    item,
	input  logic        empty,
	input  logic        pop,
	input  out_item_t   result,
	output int unsigned errors,
	output int unsigned awaiting
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [SEQ_BITS-1:0]  want_seq     [FLOWS];
	logic                 slot_full    [FLOWS][WINDOW];
	logic [LEN_BITS-1:0]  slot_flits   [FLOWS][WINDOW];
	logic [PARK_BITS-1:0] parked_sum   [FLOWS];
	logic [CNT_BITS-1:0]  in_order_cnt [FLOWS];
	logic [CNT_BITS-1:0]  drained_cnt  [FLOWS];
	out_item_t            awaited_results[$];

	initial errors = 0;
	initial awaiting = 0;

	function automatic logic [CNT_BITS-1:0] plus_one_sat(input logic [CNT_BITS-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Applies one arriving head to the flow state and returns the result it must yield.
	function automatic out_item_t track_arrival(input in_item_t pkt);
		int unsigned f;
		int unsigned rel;
		int unsigned k;
		logic [SEQ_BITS-1:0] d;
		out_item_t o;
		f = pkt.flow;
		d = pkt.packet_seq - want_seq[f];
		rel = 0;
		o = '0;
		if (d == '0) begin
			rel = 1;
			in_order_cnt[f] = plus_one_sat(in_order_cnt[f]);
			while (rel < WINDOW && slot_full[f][rel]) begin
				parked_sum[f] = parked_sum[f] - slot_flits[f][rel];
				in_order_cnt[f] = plus_one_sat(in_order_cnt[f]);
				drained_cnt[f] = plus_one_sat(drained_cnt[f]);
				rel++;
			end
			for (k = 0; k < WINDOW; k++) begin
				if (k + rel < WINDOW) begin
					slot_full[f][k] = slot_full[f][k + rel];
					slot_flits[f][k] = slot_flits[f][k + rel];
				end else begin
					slot_full[f][k] = 1'b0;
				end
			end
			want_seq[f] = want_seq[f] + SEQ_BITS'(rel);
			o.status = ST_IN_ORDER;
		end else if (d < WINDOW) begin
			if (slot_full[f][d[WIN_BITS-1:0]]) begin
				o.status = ST_STALE;
			end else begin
				slot_full[f][d[WIN_BITS-1:0]] = 1'b1;
				slot_flits[f][d[WIN_BITS-1:0]] = pkt.flit_length;
				parked_sum[f] = parked_sum[f] + pkt.flit_length;
				o.status = ST_PARKED;
			end
		end else if (d[SEQ_BITS-1]) begin
			o.status = ST_STALE;
		end else begin
			o.status = ST_BEYOND;
		end
		o.released = REL_BITS'(rel);
		o.flow_parked_flits = parked_sum[f];
		o.flow_received = in_order_cnt[f];
		o.flow_out_of_order = drained_cnt[f];
		o.next_expected = want_seq[f];
		return o;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			for (int f = 0; f < FLOWS; f++) begin
				want_seq[f] = '0;
				parked_sum[f] = '0;
				in_order_cnt[f] = '0;
				drained_cnt[f] = '0;
				for (int k = 0; k < WINDOW; k++) begin
					slot_full[f][k] = 1'b0;
					slot_flits[f][k] = '0;
				end
			end
			awaited_results.delete();
			awaiting <= 0;
		end else begin
			if (pop && !empty) begin
				if (awaited_results.size() == 0) begin
					report("result with none outstanding", 32'(result.status), 0);
				end else begin
					want = awaited_results.pop_front();
					if (result.status !== want.status)
						report("status", 32'(result.status), 32'(want.status));
					if (result.released !== want.released)
						report("released", 32'(result.released), 32'(want.released));
					if (result.flow_parked_flits !== want.flow_parked_flits)
						report("flow_parked_flits", 32'(result.flow_parked_flits),
							32'(want.flow_parked_flits));
					if (result.flow_received !== want.flow_received)
						report("flow_received", result.flow_received, want.flow_received);
					if (result.flow_out_of_order !== want.flow_out_of_order)
						report("flow_out_of_order", result.flow_out_of_order,
							want.flow_out_of_order);
					if (result.next_expected !== want.next_expected)
						report("next_expected", 32'(result.next_expected),
							32'(want.next_expected));
				end
			end
			if (push && !full)
				awaited_results.push_back(track_arrival(item));
			awaiting <= awaited_results.size();
		end
	end

endmodule

// ===== sim/packet_reorder_tracker_test.sv =====
module packet_reorder_tracker_test;
	import prt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	in_item_t    item = '0;
	logic        empty;
	logic        pop = 1'b0;
	out_item_t   result;
	int unsigned errors;
	int unsigned awaiting;

	// Percent chances that each side holds back (the sender before each head, the receiver each cycle); changed per phase.
	int unsigned send_idle = 10;
	int unsigned recv_idle = 64;
	int unsigned items_sent = 0;

	// The sender's own idea of the next expected sequence number of each flow. It only
	// shapes the stimulus; the checker keeps the real prediction.
	logic [SEQ_BITS-1:0] next_seq [FLOWS] = '{default: '0};

	packet_reorder_tracker u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	prt_result_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.errors   (errors),
		.awaiting (awaiting)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The slowest legal run is far shorter than this: about 2000 transactions, each at
	// worst a full drain of the window while the receiver idles most of the time.
	initial begin
		#5_000_000;
		$display("packet_reorder_tracker_test: FAIL");
		$finish;
	end

	// Lengths lean towards the extremes so that the parked-flit sums reach their top.
	function automatic logic [LEN_BITS-1:0] random_len();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 10)
			return '0;
		else if (pick < 20)
			return '1;
		return LEN_BITS'($urandom_range(255));
	endfunction

	// Offers one packet head and returns at the clock edge on which the transaction is
	// taken. An optional gap beforehand gives the sender's idling.
	task automatic send_head(input int unsigned fl, input logic [SEQ_BITS-1:0] seq,
			input logic [LEN_BITS-1:0] len);
		in_item_t h;
		h.flow = FLOW_BITS'(fl);
		h.packet_seq = seq;
		h.flit_length = len;
		if ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		item <= h;
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
	endtask

	// Sends the next n sequence numbers of one flow in a shuffled or reversed order, so
	// that most of them are parked and then drained by the one that closes the gap.
	// Now and then a stray head is slipped in: a repeat of one already sent (stale or
	// duplicate), one beyond the window, or one well behind the expected number.
	task automatic run_burst(input int unsigned fl, input int unsigned n, input bit reversed);
		int unsigned order [WINDOW];
		int unsigned k;
		int unsigned j;
		int unsigned tmp;
		logic [SEQ_BITS-1:0] base;
		logic [SEQ_BITS-1:0] seq;
		base = next_seq[fl];
		for (k = 0; k < n; k++)
			order[k] = reversed ? n - 1 - k : k;
		if (!reversed) begin
			for (k = n - 1; k > 0; k--) begin
				j = $urandom_range(k);
				tmp = order[k];
				order[k] = order[j];
				order[j] = tmp;
			end
		end
		for (k = 0; k < n; k++) begin
			send_head(fl, base + SEQ_BITS'(order[k]), random_len());
			if ($urandom_range(99) < 8) begin
				case ($urandom_range(2))
					0: begin
						seq = base + SEQ_BITS'(order[$urandom_range(k)]);
					end
					1: begin
						seq = base + SEQ_BITS'($urandom_range(WINDOW, 16'h7FFF));
					end
					default: begin
						seq = base + SEQ_BITS'($urandom_range(16'h8000, 16'hFFFF));
					end
				endcase
				send_head(fl, seq, random_len());
			end
		end
		next_seq[fl] = base + SEQ_BITS'(n);
	endtask

	// Receiver. Once, early on, it stops taking results for a long stretch while the
	// sender keeps offering, so that both internal queues fill and full is raised.
	initial begin
		int unsigned taken;
		bit held;
		taken = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty)
				taken++;
			if (taken == 120 && !held) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (400) @(posedge clk);
			end else begin
				pop <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	initial begin
		int unsigned phase;
		int unsigned target;
		int unsigned pick;
		int unsigned n;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed transactions. Flow 0 walks through every way a head can be judged:
		// released in order, parked at the far edge of the window, one step beyond the
		// window, a duplicate of the parked one, stale just behind the expected number,
		// stale at exactly half the sequence space behind, and beyond at just under half.
		send_head(0, 16'h0000, 8'hFF);
		send_head(0, 16'h0020, 8'h00);
		send_head(0, 16'h0021, 8'hFF);
		send_head(0, 16'h0020, 8'h11);
		send_head(0, 16'h0000, 8'h01);
		send_head(0, 16'h8001, 8'hAA);
		send_head(0, 16'h8000, 8'h55);
		send_head(0, 16'hFFFF, 8'h03);
		// Flow 15 parks two successors in reverse and drains both with the third.
		send_head(15, 16'h0002, 8'hFF);
		send_head(15, 16'h0001, 8'h80);
		send_head(15, 16'h0000, 8'h07);
		// A zero-length packet parked and drained on flow 5, and a lone release on flow 9.
		send_head(5, 16'h0001, 8'h00);
		send_head(5, 16'h0000, 8'hC8);
		send_head(9, 16'h0000, 8'h00);
		// Flow 0 keeps sequence number 32 parked. Later bursts on that flow stay sound:
		// a resend of 32 is merely judged a duplicate or stale, and the flow's expected
		// number can run one ahead of the sender's view only while that view is 32.
		next_seq[0] = 16'd1;
		next_seq[5] = 16'd2;
		next_seq[9] = 16'd1;
		next_seq[15] = 16'd3;

		// Three random phases: sender seldom idle and receiver often, then the reverse,
		// then both flat out. Between phases the sender waits for every result.
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle = 10;
					recv_idle = 64;
				end
				1: begin
					send_idle = 64;
					recv_idle = 10;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			target = items_sent + 660;
			while (items_sent < target) begin
				pick = $urandom_range(99);
				if (pick < 62)
					n = $urandom_range(1, 3);
				else if (pick < 96)
					n = $urandom_range(4, 10);
				else
					n = WINDOW;
				run_burst($urandom_range(FLOWS - 1), n,
					(n == WINDOW) ? 1'($urandom_range(1)) : ($urandom_range(2) == 0));
			end
			push <= 1'b0;
			do @(posedge clk); while (awaiting != 0);
		end

		// Let any stray result show up before the verdict.
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("packet_reorder_tracker_test: PASS");
		else
			$display("packet_reorder_tracker_test: FAIL");
		$finish;
	end

endmodule
